// ----- hw/rtl/led_cube_frame_loader_and_scan_macros.svh -----
// Assertion macros for the LED cube frame loader and scan block.
// Used by the checker; no other dependencies.
`ifndef LED_CUBE_FRAME_LOADER_AND_SCAN_MACROS_SVH
`define LED_CUBE_FRAME_LOADER_AND_SCAN_MACROS_SVH

// same-cycle implication, disabled during reset
`define LCFLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcfls assertion failed");

// next-cycle implication, disabled during reset
`define LCFLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcfls assertion failed");

`endif

// ----- hw/rtl/lcfls_pkg.sv -----
// Shared types and constants for the LED cube frame loader and scan block.
// No dependencies.
`default_nettype none

package lcfls_pkg;

    localparam int CUBE_SIDE_DEFAULT = 8;
    localparam logic [7:0] START_CODE_RESET = 8'hF2;

    localparam int ROW_SEL_W     = 3;
    localparam int DATA_W        = 8;
    localparam int LAYER_DRIVE_W = 8;

    typedef enum logic {
        REQ_RX_BYTE   = 1'b0,
        REQ_SCAN_TICK = 1'b1
    } req_type_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lcfls_frame_ram.sv -----
// Frame store: two frame buffers in one simple dual-port RAM.
// One write port, one registered read port; depends on lcfls_pkg.
`default_nettype none

module lcfls_frame_ram #(
    parameter int CUBE_SIDE = lcfls_pkg::CUBE_SIDE_DEFAULT
) (
    input  wire logic                                        aclk,
    input  wire logic                                        wr_en,
    input  wire logic [$clog2(2*CUBE_SIDE*CUBE_SIDE)-1:0]    wr_addr,
    input  wire logic [lcfls_pkg::DATA_W-1:0]                wr_data,
    input  wire logic                                        rd_en,
    input  wire logic [$clog2(2*CUBE_SIDE*CUBE_SIDE)-1:0]    rd_addr,
    output logic      [lcfls_pkg::DATA_W-1:0]                rd_data
);

    localparam int DEPTH = 2 * CUBE_SIDE * CUBE_SIDE;

    logic [lcfls_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lcfls_ctrl.sv -----
// Frame loader and scan sequencer: byte loading, buffer swap, row reads, output register.
// Depends on lcfls_pkg; drives the ports of lcfls_frame_ram.
`default_nettype none

module lcfls_ctrl #(
    parameter int CUBE_SIDE = lcfls_pkg::CUBE_SIDE_DEFAULT
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic [7:0]                                  start_code,
    input  wire logic                                        s_valid,
    output logic                                             s_ready,
    input  wire logic                                        s_req_type,
    input  wire logic [7:0]                                  s_rx_byte,
    output logic                                             m_valid,
    input  wire logic                                        m_ready,
    output logic      [lcfls_pkg::ROW_SEL_W-1:0]             m_row_select,
    output logic      [lcfls_pkg::DATA_W-1:0]                m_row_data,
    output logic      [lcfls_pkg::LAYER_DRIVE_W-1:0]         m_layer_drive,
    output logic                                             m_last,
    output logic                                             ram_wr_en,
    output logic      [$clog2(2*CUBE_SIDE*CUBE_SIDE)-1:0]    ram_wr_addr,
    output logic      [lcfls_pkg::DATA_W-1:0]                ram_wr_data,
    output logic                                             ram_rd_en,
    output logic      [$clog2(2*CUBE_SIDE*CUBE_SIDE)-1:0]    ram_rd_addr,
    input  wire logic [lcfls_pkg::DATA_W-1:0]                ram_rd_data
);

    localparam int FRAME_BYTES = CUBE_SIDE * CUBE_SIDE;
    localparam int ADDR_W      = $clog2(2 * FRAME_BYTES);
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam int ROW_W       = $clog2(CUBE_SIDE);
    localparam int RSW         = lcfls_pkg::ROW_SEL_W;
    localparam int LDW         = lcfls_pkg::LAYER_DRIVE_W;
    localparam int DW          = lcfls_pkg::DATA_W;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t           state_reg,        state_next;
    logic             receiving_reg,    receiving_next;
    logic             front_sel_reg,    front_sel_next;
    logic             front_loaded_reg, front_loaded_next;
    logic [CNT_W-1:0] byte_cnt_reg,     byte_cnt_next;
    logic [ROW_W-1:0] layer_reg,        layer_next;
    logic [ROW_W-1:0] row_reg,          row_next;
    logic             pend_reg,         pend_next;
    logic [ROW_W-1:0] pend_row_reg,     pend_row_next;
    logic [ROW_W-1:0] pend_layer_reg,   pend_layer_next;
    logic             pend_zero_reg,    pend_zero_next;
    logic             out_valid_reg,    out_valid_next;
    logic [RSW-1:0]   out_row_reg,      out_row_next;
    logic [DW-1:0]    out_data_reg,     out_data_next;
    logic [LDW-1:0]   out_layer_reg,    out_layer_next;
    logic             out_last_reg,     out_last_next;

    logic                 accept;
    logic                 byte_acc;
    logic                 take;
    logic                 out_free;
    logic                 move;
    logic                 issue;
    logic                 last_row;
    logic                 last_byte;
    logic                 pend_last;
    logic [ADDR_W-1:0]    front_base;
    logic [ADDR_W-1:0]    back_base;
    logic [CUBE_SIDE-1:0] layer_onehot;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid & s_ready;
    assign byte_acc  = accept & (s_req_type == lcfls_pkg::REQ_RX_BYTE);
    assign take      = out_valid_reg & m_ready;
    assign out_free  = ~out_valid_reg | take;
    assign move      = pend_reg & out_free;
    // next read only once the RAM output register is free or drains this cycle
    assign issue     = (state_reg == ST_SCAN) & (~pend_reg | move);
    assign last_row  = (row_reg == ROW_W'(CUBE_SIDE - 1));
    assign last_byte = (byte_cnt_reg == CNT_W'(FRAME_BYTES - 1));
    assign pend_last = (pend_row_reg == ROW_W'(CUBE_SIDE - 1));

    assign front_base   = front_sel_reg ? ADDR_W'(FRAME_BYTES) : '0;
    assign back_base    = front_sel_reg ? '0 : ADDR_W'(FRAME_BYTES);
    assign layer_onehot = {{(CUBE_SIDE - 1){1'b0}}, 1'b1} << pend_layer_reg;

    // writes hit the back buffer, reads the front one: never the same entry
    assign ram_wr_en   = byte_acc & receiving_reg;
    assign ram_wr_addr = back_base + ADDR_W'(byte_cnt_reg);
    assign ram_wr_data = s_rx_byte;
    assign ram_rd_en   = issue;
    assign ram_rd_addr = front_base + ADDR_W'(layer_reg) * ADDR_W'(CUBE_SIDE)
                         + ADDR_W'(row_reg);

    assign m_valid       = out_valid_reg;
    assign m_row_select  = out_row_reg;
    assign m_row_data    = out_data_reg;
    assign m_layer_drive = out_layer_reg;
    assign m_last        = out_last_reg;

    always_comb begin
        state_next        = state_reg;
        receiving_next    = receiving_reg;
        front_sel_next    = front_sel_reg;
        front_loaded_next = front_loaded_reg;
        byte_cnt_next     = byte_cnt_reg;
        layer_next        = layer_reg;
        row_next          = row_reg;
        pend_row_next     = pend_row_reg;
        pend_layer_next   = pend_layer_reg;
        pend_zero_next    = pend_zero_reg;
        out_valid_next    = out_valid_reg;
        out_row_next      = out_row_reg;
        out_data_next     = out_data_reg;
        out_layer_next    = out_layer_reg;
        out_last_next     = out_last_reg;

        if (byte_acc) begin
            if (!receiving_reg) begin
                if (s_rx_byte == start_code) begin
                    receiving_next = 1'b1;
                    byte_cnt_next  = '0;
                end
            end else if (last_byte) begin
                // swap; the old front is logically cleared and gets fully
                // rewritten before it can be shown again
                front_sel_next    = ~front_sel_reg;
                front_loaded_next = 1'b1;
                receiving_next    = 1'b0;
                byte_cnt_next     = '0;
            end else begin
                byte_cnt_next = byte_cnt_reg + 1'b1;
            end
        end

        if (accept && s_req_type == lcfls_pkg::REQ_SCAN_TICK) begin
            state_next = ST_SCAN;
            row_next   = '0;
        end

        if (issue) begin
            pend_row_next   = row_reg;
            pend_layer_next = layer_reg;
            // buffer never loaded since reset reads as zero
            pend_zero_next  = ~front_loaded_reg;
            if (last_row) begin
                state_next = ST_IDLE;
                layer_next = (layer_reg == ROW_W'(CUBE_SIDE - 1)) ? '0 : layer_reg + 1'b1;
            end else begin
                row_next = row_reg + 1'b1;
            end
        end

        pend_next = issue | (pend_reg & ~move);

        if (move) begin
            out_valid_next = 1'b1;
            out_row_next   = RSW'(pend_row_reg);
            out_data_next  = pend_zero_reg ? '0 : ram_rd_data;
            out_layer_next = pend_last ? LDW'(layer_onehot) : '0;
            out_last_next  = pend_last;
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            receiving_reg    <= 1'b0;
            front_sel_reg    <= 1'b0;
            front_loaded_reg <= 1'b0;
            byte_cnt_reg     <= '0;
            layer_reg        <= '0;
            row_reg          <= '0;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            receiving_reg    <= receiving_next;
            front_sel_reg    <= front_sel_next;
            front_loaded_reg <= front_loaded_next;
            byte_cnt_reg     <= byte_cnt_next;
            layer_reg        <= layer_next;
            row_reg          <= row_next;
            pend_reg         <= pend_next;
            out_valid_reg    <= out_valid_next;
        end
        pend_row_reg   <= pend_row_next;
        pend_layer_reg <= pend_layer_next;
        pend_zero_reg  <= pend_zero_next;
        out_row_reg    <= out_row_next;
        out_data_reg   <= out_data_next;
        out_layer_reg  <= out_layer_next;
        out_last_reg   <= out_last_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/led_cube_frame_loader_and_scan.sv -----
// Serial byte: accepted without producing a result; s_ready stays high while idle.
// Scan tick: rows pass the RAM read register and the output register, one row beat
// per cycle unless m_ready stalls (CUBE_SIDE beats a tick), set by the single read port.
// Reset (aresetn low, synchronous) empties the pipeline, shows buffer 0 as all
// zero, resets start_code to 0xF2; no clearing pass, ready right after reset.
`default_nettype none

module led_cube_frame_loader_and_scan #(
    parameter int CUBE_SIDE = lcfls_pkg::CUBE_SIDE_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration: start code
    input  wire logic                                  cfg_wr_en,
    input  wire logic [7:0]                            cfg_wr_data,
    // request channel
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_req_type,
    input  wire logic [7:0]                            s_rx_byte,
    // row result channel
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic      [lcfls_pkg::ROW_SEL_W-1:0]       m_row_select,
    output logic      [lcfls_pkg::DATA_W-1:0]          m_row_data,
    output logic      [lcfls_pkg::LAYER_DRIVE_W-1:0]   m_layer_drive,
    output logic                                       m_last
);

    localparam int ADDR_W = $clog2(2 * CUBE_SIDE * CUBE_SIDE);

    // start code register, to be written only while idle; the block does not enforce this
    logic [7:0] start_code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_code_reg <= lcfls_pkg::START_CODE_RESET;
        end else if (cfg_wr_en) begin
            start_code_reg <= cfg_wr_data;
        end
    end

    // RAM port nets
    logic                          ram_wr_en;
    logic [ADDR_W-1:0]             ram_wr_addr;
    logic [lcfls_pkg::DATA_W-1:0]  ram_wr_data;
    logic                          ram_rd_en;
    logic [ADDR_W-1:0]             ram_rd_addr;
    logic [lcfls_pkg::DATA_W-1:0]  ram_rd_data;

    // Sequencer: loads frames into the back half, walks the rows of the
    // current layer out of the front half, and holds one beat in its
    // output register; a stalled sink stalls reads when it and rd_data are full.
    lcfls_ctrl #(
        .CUBE_SIDE (CUBE_SIDE)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start_code    (start_code_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_select  (m_row_select),
        .m_row_data    (m_row_data),
        .m_layer_drive (m_layer_drive),
        .m_last        (m_last),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data)
    );

    // Both frame buffers: front half selected by the sequencer's swap bit.
    lcfls_frame_ram #(
        .CUBE_SIDE (CUBE_SIDE)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/lcfls_checker.sv -----
// Port-level checker for led_cube_frame_loader_and_scan, bound to the top level.
// Depends on lcfls_pkg and led_cube_frame_loader_and_scan_macros.svh.
`default_nettype none

`include "led_cube_frame_loader_and_scan_macros.svh"

module lcfls_checker #(
    parameter int CUBE_SIDE = lcfls_pkg::CUBE_SIDE_DEFAULT
) (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_valid,
    input wire logic                                 s_ready,
    input wire logic                                 s_req_type,
    input wire logic                                 m_valid,
    input wire logic                                 m_ready,
    input wire logic [lcfls_pkg::ROW_SEL_W-1:0]      m_row_select,
    input wire logic [lcfls_pkg::DATA_W-1:0]         m_row_data,
    input wire logic [lcfls_pkg::LAYER_DRIVE_W-1:0]  m_layer_drive,
    input wire logic                                 m_last
);

    localparam int RSW = lcfls_pkg::ROW_SEL_W;

    // stalled beat holds
    `LCFLS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_row_data) && $stable(m_last) && $stable(m_row_select))

    // layer enable only on the final row
    `LCFLS_ASSERT_IMP(a_drive_only_last, aclk, aresetn, m_valid && !m_last, m_layer_drive == '0)

    // final row carries the top row index and a one-hot layer enable
    `LCFLS_ASSERT_IMP(a_last_row, aclk, aresetn, m_valid && m_last, m_row_select == RSW'(CUBE_SIDE - 1) && (CUBE_SIDE > 8 || $onehot(m_layer_drive)))

    // a scan tick occupies the block while its rows are read
    `LCFLS_ASSERT_NXT(a_tick_busy, aclk, aresetn, s_valid && s_ready && s_req_type == lcfls_pkg::REQ_SCAN_TICK, !s_ready)

endmodule

bind led_cube_frame_loader_and_scan lcfls_checker #(
    .CUBE_SIDE (CUBE_SIDE)
) u_lcfls_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_req_type    (s_req_type),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_row_select  (m_row_select),
    .m_row_data    (m_row_data),
    .m_layer_drive (m_layer_drive),
    .m_last        (m_last)
);

`default_nettype wire

// ----- test/tb_led_cube_frame_loader_and_scan.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for led_cube_frame_loader_and_scan: serial frame loading,
// buffer swap and layer-by-layer row scan. Needs lcfls_pkg and the block's RTL.

module tb_led_cube_frame_loader_and_scan;
    import lcfls_pkg::*;

    localparam int SIDE          = CUBE_SIDE_DEFAULT;
    localparam int FRAME_BYTES   = SIDE * SIDE;
    localparam int TOTAL_ITEMS   = 470;
    localparam int NUM_PHASES    = 5;
    localparam int STEADY_PHASE  = 2;      // phase run with neither side idling
    localparam int IDLE_PCT      = 14;
    localparam int SETTLE_CYCLES = SIDE + 6;
    // Cycle limit well over the slowest correct run (every tick 8 rows, every row stalled
    // by the sink, every beat delayed by a sender gap), as a guard against a hang.
    localparam int CYCLE_LIMIT   = 200000;

    // One beat of the request channel.
    typedef struct {
        req_type_t  kind;
        logic [7:0] rx_byte;
    } cube_req_t;

    // One row beat as the block should present it.
    typedef struct {
        logic [ROW_SEL_W-1:0]     row_select;
        logic [DATA_W-1:0]        row_data;
        logic [LAYER_DRIVE_W-1:0] layer_drive;
        logic                     last;
    } row_beat_t;

    // ---------------------------------------------------------------- DUT ports
    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [7:0]               cfg_wr_data = 8'h00;
    logic                     s_valid     = 1'b0;
    logic                     s_req_type  = 1'b0;
    logic [7:0]               s_rx_byte   = 8'h00;
    logic                     m_ready     = 1'b0;
    wire                      s_ready;
    wire                      m_valid;
    wire [ROW_SEL_W-1:0]      m_row_select;
    wire [DATA_W-1:0]         m_row_data;
    wire [LAYER_DRIVE_W-1:0]  m_layer_drive;
    wire                      m_last;

    led_cube_frame_loader_and_scan #(
        .CUBE_SIDE(SIDE)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_select (m_row_select),
        .m_row_data   (m_row_data),
        .m_layer_drive(m_layer_drive),
        .m_last       (m_last)
    );

    // 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------- bench state
    cube_req_t   req_backlog[$];    // beats waiting for the driver
    row_beat_t   rows_due[$];       // row beats still owed by the block
    bit          req_taken     = 1'b0;
    bit          steady        = 1'b0;
    int unsigned items_queued  = 0;
    int unsigned items_taken   = 0;
    int unsigned rows_checked  = 0;
    int unsigned cycle_count   = 0;
    int unsigned errors        = 0;

    // Shadow of the cube: two frame buffers, loader and scan state, start code.
    logic [7:0]  frame_buf [0:1][0:FRAME_BYTES-1];
    logic        front_sel;
    logic        loading;
    int unsigned load_count;
    int unsigned scan_layer;
    logic [7:0]  start_code;
    int unsigned frames_swapped = 0;
    int unsigned ticks_seen     = 0;
    int unsigned bytes_seen     = 0;

    task automatic clear_shadow();
        for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                frame_buf[b][i] = 8'h00;
            end
        end
        front_sel  = 1'b0;
        loading    = 1'b0;
        load_count = 0;
        scan_layer = 0;
        start_code = START_CODE_RESET;
    endtask

    // Advance the shadow by one accepted beat; a scan tick queues its row beats.
    task automatic predict_rows(input req_type_t kind, input logic [7:0] data);
        row_beat_t beat;
        int unsigned layer;
        if (kind == REQ_RX_BYTE) begin
            bytes_seen++;
            if (!loading) begin
                // outside a frame only the start code matters
                if (data == start_code) begin
                    loading    = 1'b1;
                    load_count = 0;
                end
            end else begin
                // inside a frame every byte is pixel data, start code included
                frame_buf[~front_sel][load_count] = data;
                load_count++;
                if (load_count == FRAME_BYTES) begin
                    // last byte: swap, then wipe what is now the back buffer
                    front_sel = ~front_sel;
                    for (int i = 0; i < FRAME_BYTES; i++) begin
                        frame_buf[~front_sel][i] = 8'h00;
                    end
                    loading    = 1'b0;
                    load_count = 0;
                    frames_swapped++;
                end
            end
        end else begin
            ticks_seen++;
            layer = scan_layer;
            for (int row = 0; row < SIDE; row++) begin
                beat.row_select  = ROW_SEL_W'(row);
                beat.row_data    = frame_buf[front_sel][layer * SIDE + row];
                beat.layer_drive = (row == SIDE - 1) ? LAYER_DRIVE_W'(1 << layer) : '0;
                beat.last        = (row == SIDE - 1);
                rows_due.push_back(beat);
            end
            scan_layer = (layer + 1) % SIDE;
        end
    endtask

    // ------------------------------------------------------------- stimulus
    task automatic push_item(input req_type_t kind, input logic [7:0] data);
        cube_req_t item;
        item.kind    = kind;
        item.rx_byte = data;
        req_backlog.push_back(item);
        items_queued++;
    endtask

    // Start code followed by len bytes; len < FRAME_BYTES leaves the frame cut short,
    // so the next start code lands inside it as data. Ticks are sprinkled in to check
    // that a half-loaded frame never shows.
    task automatic queue_frame(input logic [7:0] code, input int len);
        int style;
        logic [7:0] pix;
        style = $urandom_range(0, 3);
        push_item(REQ_RX_BYTE, code);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 10) begin
                push_item(REQ_SCAN_TICK, 8'($urandom));
            end
            case (style)
                0, 1: begin
                    pix = 8'($urandom);
                end
                2: begin
                    // extremes, and the start code stored as pixel data
                    case ($urandom_range(0, 3))
                        0:       pix = 8'h00;
                        1:       pix = 8'hFF;
                        2:       pix = code;
                        default: pix = 8'($urandom);
                    endcase
                end
                default: begin
                    pix = 8'((i * 37) ^ code);
                end
            endcase
            push_item(REQ_RX_BYTE, pix);
        end
    endtask

    // Mostly whole frames; some loose bytes and ticks and some truncated frames.
    task automatic queue_random_chunk(input logic [7:0] code);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            queue_frame(code, FRAME_BYTES);
        end else if (pick < 86) begin
            repeat ($urandom_range(1, 6)) begin
                push_item(req_type_t'($urandom_range(0, 1)), 8'($urandom));
            end
        end else begin
            queue_frame(code, $urandom_range(1, FRAME_BYTES - 1));
        end
        // scan a run of layers, sometimes past the wrap
        repeat ($urandom_range(1, SIDE + 1)) begin
            push_item(REQ_SCAN_TICK, 8'($urandom));
        end
    endtask

    // Sender holds off until every beat is taken and every row has come back.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (items_taken != items_queued || rows_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // --------------------------------------------------------------- driver
    // Inputs change on the falling edge; a beat counts as taken at the rising edge.
    always @(negedge aclk) begin
        cube_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            req_taken = 1'b0;
            if (req_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = req_backlog.pop_front();
                s_valid    <= 1'b1;
                s_req_type <= nxt.kind;
                s_rx_byte  <= nxt.rx_byte;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Register writes and accepted request beats update the shadow at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                start_code = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                predict_rows(req_type_t'(s_req_type), s_rx_byte);
                items_taken++;
                req_taken = 1'b1;
            end
        end
    end

    // -------------------------------------------------------------- monitor
    always @(posedge aclk) begin
        row_beat_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_led_cube_frame_loader_and_scan: FAIL");
            $finish;
        end else if (aresetn && m_valid && m_ready) begin
            if (rows_due.size() == 0) begin
                $error("row beat with none pending: row_select %0d row_data %02h",
                       m_row_select, m_row_data);
                errors++;
            end else begin
                want = rows_due.pop_front();
                rows_checked++;
                if (m_row_select !== want.row_select) begin
                    $error("row_select: expected %0h, actual %0h", want.row_select, m_row_select);
                    errors++;
                end
                if (m_row_data !== want.row_data) begin
                    $error("row_data: expected %0h, actual %0h", want.row_data, m_row_data);
                    errors++;
                end
                if (m_layer_drive !== want.layer_drive) begin
                    $error("layer_drive: expected %0h, actual %0h",
                           want.layer_drive, m_layer_drive);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0h, actual %0h", want.last, m_last);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------ sequencer
    initial begin
        logic [7:0] code_now;
        int unsigned phase_goal;
        clear_shadow();
        code_now = START_CODE_RESET;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed opening, reset start code.
        push_item(REQ_SCAN_TICK, 8'h00);     // both buffers zero after reset
        push_item(REQ_SCAN_TICK, 8'hFF);     // byte field ignored on a tick
        push_item(REQ_RX_BYTE, 8'h00);       // no frame open: all ignored
        push_item(REQ_RX_BYTE, 8'hFF);
        push_item(REQ_RX_BYTE, 8'hF3);
        push_item(REQ_RX_BYTE, 8'h72);
        push_item(REQ_RX_BYTE, code_now);    // opens a frame
        push_item(REQ_RX_BYTE, code_now);    // start code inside a frame is data
        push_item(REQ_RX_BYTE, 8'hFF);
        push_item(REQ_RX_BYTE, 8'h00);
        push_item(REQ_RX_BYTE, 8'h01);
        push_item(REQ_RX_BYTE, 8'h80);
        push_item(REQ_SCAN_TICK, 8'hA5);     // frame in progress must not show
        // Rest of that frame, then a full sweep of layers through the wrap.
        for (int i = 5; i < FRAME_BYTES; i++) begin
            push_item(REQ_RX_BYTE, 8'($urandom));
        end
        repeat (SIDE + 1) push_item(REQ_SCAN_TICK, 8'($urandom));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                // only touch the start code with the block idle
                wait_drained();
                case (phase)
                    1:       code_now = 8'h00;
                    2:       code_now = 8'hFF;
                    default: code_now = 8'($urandom);
                endcase
                cfg_wr_en   = 1'b1;
                cfg_wr_data = code_now;
                @(negedge aclk);
                cfg_wr_en   = 1'b0;
            end
            steady     = (phase == STEADY_PHASE);
            phase_goal = (phase + 1) * TOTAL_ITEMS / NUM_PHASES;
            while (items_queued < phase_goal) begin
                queue_random_chunk(code_now);
            end
        end

        wait_drained();
        $display("Run covered %0d request beats (%0d serial bytes, %0d scan ticks), %0d frames",
                 items_taken, bytes_seen, ticks_seen, frames_swapped);
        $display("swapped in, %0d row beats checked over %0d start code settings.",
                 rows_checked, NUM_PHASES);
        if (errors == 0 && rows_due.size() == 0) begin
            $display("tb_led_cube_frame_loader_and_scan: PASS");
        end else begin
            $display("tb_led_cube_frame_loader_and_scan: FAIL");
        end
        $finish;
    end

endmodule
